FILE: rtl/msadpcm_pkg.sv
// Shared types, constants and coefficient tables of the MS ADPCM block decoder.
`timescale 1ns / 1ps

package msadpcm_pkg;

    localparam int CC_W     = 2;   // channel_count register width
    localparam int SPB_W    = 14;  // samples_per_block register width
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = SPB_W;
    localparam int PHASE_W  = 4;
    localparam int SUB_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 1'd1;

    localparam logic [CC_W-1:0]  CC_MONO   = 2'd1;
    localparam logic [CC_W-1:0]  CC_STEREO = 2'd2;
    localparam logic [CC_W-1:0]  CC_RESET  = CC_MONO;
    localparam logic [SPB_W-1:0] SPB_RESET = 14'd500;

    localparam logic [PHASE_W-1:0] LAST_PHASE_MONO   = 4'd6;
    localparam logic [PHASE_W-1:0] LAST_PHASE_STEREO = 4'd13;

    localparam logic [2:0] MAX_PREDICTOR = 3'd6;
    localparam logic signed [15:0] MIN_STEP = 16'sd16;
    localparam logic [3:0] SIGN_BIT_MASK = 4'h8;

    // Header word kinds
    localparam logic [1:0] KIND_STEP  = 2'd0;
    localparam logic [1:0] KIND_PREV  = 2'd1;
    localparam logic [1:0] KIND_OLDER = 2'd2;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               channel;
        logic               from_header;
        logic               bad_predictor;
        logic               last;
    } result_t;

    function automatic logic signed [10:0] coef_a(input logic [2:0] idx);
        logic signed [10:0] c;
        case (idx)
            3'd0:    c = 11'sd256;
            3'd1:    c = 11'sd512;
            3'd2:    c = 11'sd0;
            3'd3:    c = 11'sd192;
            3'd4:    c = 11'sd240;
            3'd5:    c = 11'sd460;
            3'd6:    c = 11'sd392;
            default: c = 11'sd256;
        endcase
        return c;
    endfunction

    function automatic logic signed [9:0] coef_b(input logic [2:0] idx);
        logic signed [9:0] c;
        case (idx)
            3'd0:    c = 10'sd0;
            3'd1:    c = -10'sd256;
            3'd2:    c = 10'sd0;
            3'd3:    c = 10'sd64;
            3'd4:    c = 10'sd0;
            3'd5:    c = -10'sd208;
            3'd6:    c = -10'sd232;
            default: c = 10'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [9:0] adapt_factor(input logic [3:0] code);
        logic [9:0] f;
        case (code)
            4'd0, 4'd1, 4'd2, 4'd3: f = 10'd230;
            4'd4:                   f = 10'd307;
            4'd5:                   f = 10'd409;
            4'd6:                   f = 10'd512;
            4'd7:                   f = 10'd614;
            4'd8:                   f = 10'd768;
            4'd9:                   f = 10'd614;
            4'd10:                  f = 10'd512;
            4'd11:                  f = 10'd409;
            4'd12:                  f = 10'd307;
            default:                f = 10'd230;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/msadpcm_nibble.sv
// One-nibble ADPCM decode: prediction, clamp and step adaptation.
`timescale 1ns / 1ps

module msadpcm_nibble (
    input  logic [3:0]         code,
    input  logic [2:0]         pred,
    input  logic signed [15:0] step,
    input  logic signed [15:0] s1,
    input  logic signed [15:0] s2,
    output logic signed [15:0] sample,
    output logic signed [15:0] step_new
);
    import msadpcm_pkg::*;

    logic signed [10:0] ca;
    logic signed [9:0]  cb;
    logic signed [27:0] acc;
    logic signed [27:0] acc_adj;
    logic signed [19:0] pred_q;
    logic signed [3:0]  sn;
    logic signed [19:0] dl;
    logic signed [21:0] v;
    logic signed [10:0] af;
    logic signed [26:0] ap;
    logic signed [26:0] ap_adj;
    logic signed [26:0] ap_q;
    logic signed [15:0] w;

    always_comb
    begin
        ca      = coef_a(pred);
        cb      = coef_b(pred);
        acc     = 28'(s1) * 28'(ca) + 28'(s2) * 28'(cb);
        // truncate toward zero
        acc_adj = acc + (acc[27] ? 28'sd255 : 28'sd0);
        pred_q  = 20'(acc_adj >>> 8);
        sn      = $signed(code);
        dl      = 20'(sn) * 20'(step);
        v       = 22'(pred_q) + 22'(dl);
        if (v < -22'sd32768)
            sample = -16'sd32768;
        else if (v > 22'sd32767)
            sample = 16'sd32767;
        else
            sample = 16'(v);

        af      = $signed({1'b0, adapt_factor(code)});
        ap      = 27'(af) * 27'(step);
        ap_adj  = ap + (ap[26] ? 27'sd255 : 27'sd0);
        ap_q    = ap_adj >>> 8;
        w       = ap_q[15:0];
        step_new = (w < MIN_STEP) ? MIN_STEP : w;
    end

endmodule

FILE: rtl/msadpcm_ctrl.sv
// Block parser and sequencer: header fields, channel state, one result per step.
`timescale 1ns / 1ps

module msadpcm_ctrl #(
    parameter int MAX_BLOCK_SAMPLES = 8192
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr,
    input  logic [msadpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msadpcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                 hold_valid,
    input  logic [7:0]                           hold_byte,
    input  logic                                 out_free,
    output logic                                 consume,
    output logic                                 emit,
    output msadpcm_pkg::result_t                 result
);
    import msadpcm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES);
    localparam int A_W   = $clog2(MAX_BLOCK_SAMPLES + 1);

    logic [CC_W-1:0]    cc_reg;
    logic [SPB_W-1:0]   spb_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [7:0]         low_reg, low_next;
    logic [2:0]         pred_reg [2];
    logic [2:0]         pred_next [2];
    logic               bad_reg [2];
    logic               bad_next [2];
    logic signed [15:0] step_reg [2];
    logic signed [15:0] step_next [2];
    logic signed [15:0] prev_reg [2];
    logic signed [15:0] prev_next [2];
    logic signed [15:0] old_reg [2];
    logic signed [15:0] old_next [2];

    logic               cc_ok, stereo;
    logic [PHASE_W-1:0] npred, last_phase, q;
    logic [2:0]         pair;
    logic [1:0]         kind;
    logic               wr_ch, ch_sel;
    logic [SUB_W-1:0]   last_sub;
    logic               hdr_prev;
    logic [3:0]         code;
    logic signed [15:0] dec_sample, dec_step;
    logic signed [15:0] word;
    logic [A_W-1:0]     a_lim;
    logic [CNT_W-1:0]   block_bytes;

    msadpcm_nibble u_nibble (
        .code     (code),
        .pred     (pred_reg[ch_sel]),
        .step     (step_reg[ch_sel]),
        .s1       (prev_reg[ch_sel]),
        .s2       (old_reg[ch_sel]),
        .sample   (dec_sample),
        .step_new (dec_step)
    );

    // Data bytes per block for the current configuration
    always_comb
    begin
        if (32'(spb_reg) > 32'(MAX_BLOCK_SAMPLES))
            a_lim = A_W'(MAX_BLOCK_SAMPLES);
        else
            a_lim = A_W'(spb_reg);
        if (a_lim < A_W'(3))
            block_bytes = '0;
        else if (stereo)
            block_bytes = CNT_W'(a_lim - A_W'(2));
        else
            block_bytes = CNT_W'((a_lim - A_W'(1)) >> 1);
    end

    always_comb
    begin
        cc_ok      = (cc_reg == CC_MONO) || (cc_reg == CC_STEREO);
        stereo     = (cc_reg == CC_STEREO);
        npred      = stereo ? PHASE_W'(2) : PHASE_W'(1);
        last_phase = stereo ? LAST_PHASE_STEREO : LAST_PHASE_MONO;
        last_sub   = stereo ? SUB_W'(4) : SUB_W'(2);
        q          = phase_reg - npred;
        pair       = q[3:1];
        kind       = stereo ? pair[2:1] : pair[1:0];
        wr_ch      = stereo ? pair[0] : 1'b0;
        word       = $signed({hold_byte, low_reg});
        hdr_prev   = stereo ? (sub_reg >= SUB_W'(3)) : (sub_reg == SUB_W'(2));
        if (left_reg != '0)
            ch_sel = (sub_reg != '0) && stereo;
        else
            ch_sel = stereo && !sub_reg[0];
        code       = (sub_reg == '0) ? hold_byte[7:4] : hold_byte[3:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        sub_next   = sub_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        pred_next  = pred_reg;
        bad_next   = bad_reg;
        step_next  = step_reg;
        prev_next  = prev_reg;
        old_next   = old_reg;
        consume    = 1'b0;
        emit       = 1'b0;
        result.pcm_sample    = dec_sample;
        result.channel       = ch_sel;
        result.from_header   = 1'b0;
        result.bad_predictor = bad_reg[ch_sel];
        result.last          = 1'b0;

        if (hold_valid)
        begin
            if (!cc_ok)
            begin
                consume = 1'b1;
            end
            else if (left_reg != '0)
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    step_next[ch_sel] = dec_step;
                    prev_next[ch_sel] = dec_sample;
                    old_next[ch_sel]  = prev_reg[ch_sel];
                    if (sub_reg == '0)
                    begin
                        sub_next = SUB_W'(1);
                    end
                    else
                    begin
                        result.last = 1'b1;
                        sub_next    = '0;
                        left_next   = left_reg - CNT_W'(1);
                        consume     = 1'b1;
                    end
                end
            end
            else if (sub_reg == '0)
            begin
                if (phase_reg < npred)
                begin
                    // predictor byte: out-of-range index falls back to entry 0
                    pred_next[phase_reg[0]] = (hold_byte > 8'(MAX_PREDICTOR)) ?
                                              3'd0 : hold_byte[2:0];
                    bad_next[phase_reg[0]]  = hold_byte > 8'(MAX_PREDICTOR);
                    phase_next = phase_reg + PHASE_W'(1);
                    consume    = 1'b1;
                end
                else
                begin
                    if (!q[0])
                        low_next = hold_byte;
                    else
                    begin
                        case (kind)
                            KIND_STEP:  step_next[wr_ch] = word;
                            KIND_PREV:  prev_next[wr_ch] = word;
                            KIND_OLDER: old_next[wr_ch]  = word;
                            default:    old_next[wr_ch]  = word;
                        endcase
                    end
                    if (phase_reg < last_phase)
                    begin
                        phase_next = phase_reg + PHASE_W'(1);
                        consume    = 1'b1;
                    end
                    else
                        sub_next = SUB_W'(1);
                end
            end
            else if (out_free)
            begin
                // replay the header history samples, older first
                emit = 1'b1;
                result.from_header = 1'b1;
                result.pcm_sample  = hdr_prev ? prev_reg[ch_sel] : old_reg[ch_sel];
                if (sub_reg == last_sub)
                begin
                    result.last = 1'b1;
                    sub_next    = '0;
                    phase_next  = '0;
                    left_next   = block_bytes;
                    consume     = 1'b1;
                end
                else
                    sub_next = sub_reg + SUB_W'(1);
            end
        end

        if (cfg_wr)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT, REG_SAMPLES_PER_BLOCK:
                begin
                    phase_next = '0;
                    left_next  = '0;
                    sub_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg    <= CC_RESET;
            spb_reg   <= SPB_RESET;
            phase_reg <= '0;
            sub_reg   <= '0;
            left_reg  <= '0;
            low_reg   <= '0;
            for (int i = 0; i < 2; i++)
            begin
                pred_reg[i] <= '0;
                bad_reg[i]  <= 1'b0;
                step_reg[i] <= '0;
                prev_reg[i] <= '0;
                old_reg[i]  <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            left_reg  <= left_next;
            low_reg   <= low_next;
            pred_reg  <= pred_next;
            bad_reg   <= bad_next;
            step_reg  <= step_next;
            prev_reg  <= prev_next;
            old_reg   <= old_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT:     cc_reg  <= cfg_data[CC_W-1:0];
                    REG_SAMPLES_PER_BLOCK: spb_reg <= cfg_data[SPB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: rtl/ms_adpcm_block_decoder.sv
// Top level of the MS ADPCM block decoder: input hold register, sequencer, result register.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (data_valid / data_stall / data_byte) takes the compressed stream
//   one byte per beat. Output channel (sample_valid / sample_stall) delivers one PCM
//   sample per beat with channel, from_header, bad_predictor and last.
// - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 is channel_count, index 1 is samples_per_block. Write only while idle;
//   a write restarts block parsing but keeps the per-channel history.
// - A data byte passes through the input hold register into the nibble decoder and its
//   samples into the output register; header samples follow once the last header byte
//   is held and the parser has moved on to replay. A data byte yields two samples, one
//   per output beat, through one shared nibble decoder; it is consumed with the second.
//   Header bytes before the last are consumed as they arrive; the last header byte
//   stays held while it replays the header samples.
// - A new byte is accepted while the previous result still waits in the output
//   register; data_stall rises only while the held byte has results left to issue.
// - When sample_stall is high and a beat waits, the output register and its beat hold,
//   and the sequencer stops issuing samples until the slot frees.
// - Reset: mono, 500 samples per block, parser waiting for a predictor byte,
//   all channel history and step sizes zero.
//
module ms_adpcm_block_decoder #(
    parameter int MAX_BLOCK_SAMPLES = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [msadpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msadpcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                data_valid,
    output logic                                data_stall,
    input  logic [7:0]                          data_byte,
    output logic                                sample_valid,
    input  logic                                sample_stall,
    output logic signed [15:0]                  pcm_sample,
    output logic                                channel,
    output logic                                from_header,
    output logic                                bad_predictor,
    output logic                                last
);
    import msadpcm_pkg::*;

    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    step_result;
    logic       consume, emit, out_free, accept;

    assign cfg_ready = 1'b1;

    // Free the output slot when it is empty or its beat is taken this cycle
    assign out_free   = !out_valid_reg || !sample_stall;
    assign data_stall = hold_valid_reg && !consume;
    assign accept     = data_valid && !data_stall;

    msadpcm_ctrl #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .hold_valid (hold_valid_reg),
        .hold_byte  (hold_byte_reg),
        .out_free   (out_free),
        .consume    (consume),
        .emit       (emit),
        .result     (step_result)
    );

    always_comb
    begin
        // Drop the held byte once finished; load a new one on accept
        if (accept)
            hold_valid_next = 1'b1;
        else if (consume)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (!sample_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: advance only on accept / emit
    always_ff @(posedge clk)
    begin
        if (accept)
            hold_byte_reg <= data_byte;
        if (emit)
            out_reg <= step_result;
    end

    assign sample_valid  = out_valid_reg;
    assign pcm_sample    = out_reg.pcm_sample;
    assign channel       = out_reg.channel;
    assign from_header   = out_reg.from_header;
    assign bad_predictor = out_reg.bad_predictor;
    assign last          = out_reg.last;

endmodule
